FILE: rtl/core/ffbp_pkg.sv
// Shared types and constants of the first-fit blob placement unit.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package ffbp_pkg;

  localparam int unsigned ID_W      = 32;
  localparam int unsigned SCORE_W   = 17;
  localparam int unsigned IO_SIZE_W = 48;
  localparam int unsigned SLOT_W    = 4;
  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PLACE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_PLACED = 2'd0,
    ST_NOSOL  = 2'd1,
    ST_SKIP   = 2'd2,
    ST_LOADED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_FINISH
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic take;      // input register may take a request
    logic scan;      // walk the slot table
    logic update;    // write back the reduced capacity
    logic finish;    // move the result into the output register
  } ffbp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_scan; // offered request is a placement that must search
    logic hit;       // current slot qualifies
    logic miss;      // last slot checked without a match
    logic out_free;  // output register can take a result this cycle
  } ffbp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/ffbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ffbp_ctrl.sv
// Sequencing state machine of the placement unit.
// Depends on ffbp_pkg for the state type and the command and status structs.
`default_nettype none

module ffbp_ctrl
  import ffbp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire ffbp_sts_t sts_i,
  output ffbp_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.need_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          state_d = S_UPDATE;
        end else if (sts_i.miss) begin
          state_d = S_FINISH;
        end
      end
      S_UPDATE: state_d = S_FINISH;
      S_FINISH: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:   cmd_o.take   = 1'b1;
      S_SCAN:   cmd_o.scan   = 1'b1;
      S_UPDATE: cmd_o.update = 1'b1;
      S_FINISH: cmd_o.finish = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/ffbp_dp.sv
// Datapath of the placement unit: slot table, valid marks, scan, result registers.
// Depends on ffbp_pkg and ffbp_ram.
`default_nettype none

module ffbp_dp
  import ffbp_pkg::*;
#(
  parameter int unsigned MAX_TARGETS = 16,
  parameter int unsigned SIZE_BITS   = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [SCORE_W-1:0]   cfg_data_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 command_i,
  input  wire logic [SLOT_W-1:0]    target_slot_i,
  input  wire logic [ID_W-1:0]      target_id_i,
  input  wire logic [IO_SIZE_W-1:0] target_capacity_i,
  input  wire logic [SCORE_W-1:0]   target_score_i,
  input  wire logic [IO_SIZE_W-1:0] item_size_i,
  input  wire logic                 batch_last_i,
  input  wire logic                 out_stall_i,
  input  wire ffbp_cmd_t            cmd_i,
  output ffbp_sts_t                 sts_o,
  output logic                      out_valid_o,
  output logic [1:0]                status_o,
  output logic [ID_W-1:0]           placed_target_id_o,
  output logic [IO_SIZE_W-1:0]      placed_size_o
);

  localparam int unsigned IDX_W  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TARGETS + 1);
  localparam int unsigned WORD_W = ID_W + SCORE_W + SIZE_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TARGETS - 1);

  logic                 accept;
  logic [SCORE_W-1:0]   blob_score_q;
  logic                 batch_failed_q;
  logic [MAX_TARGETS-1:0] valid_q;
  logic [SIZE_BITS-1:0] size_q;
  logic                 last_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 rd_pend_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic [WORD_W-1:0]    hit_word_q;
  status_e              res_status_q;
  logic [ID_W-1:0]      res_id_q;
  logic [IO_SIZE_W-1:0] res_size_q;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [ID_W-1:0]      out_id_q;
  logic [IO_SIZE_W-1:0] out_size_q;

  logic [8:0]           slot_wide;
  logic                 slot_in_range;
  logic [IDX_W-1:0]     load_idx;
  logic                 is_load;
  logic                 issue;
  logic                 hit;
  logic                 miss;
  logic [WORD_W-1:0]    rd_word;
  logic [ID_W-1:0]      rd_id;
  logic [SCORE_W-1:0]   rd_score;
  logic [SIZE_BITS-1:0] rd_cap;
  logic [SIZE_BITS-1:0] new_cap;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;

  assign accept        = in_valid_i & cmd_i.take;
  assign is_load       = (command_i == CMD_LOAD);
  assign slot_wide     = 9'(target_slot_i);
  assign slot_in_range = slot_wide < 9'(MAX_TARGETS);
  assign load_idx      = slot_wide[IDX_W-1:0];

  assign {rd_id, rd_score, rd_cap} = rd_word;

  // A read issued in one cycle is checked in the next, so the scan runs one
  // slot per cycle; the read stops once a slot matches to keep its data.
  assign hit   = cmd_i.scan & rd_pend_q & valid_q[rd_idx_q] &
                 (rd_score <= blob_score_q) & (rd_cap >= size_q);
  assign miss  = cmd_i.scan & rd_pend_q & ~hit & (rd_idx_q == LAST_IDX);
  assign issue = cmd_i.scan & ~hit & (cnt_q < CNT_W'(MAX_TARGETS));

  assign new_cap   = hit_word_q[SIZE_BITS-1:0] - size_q;
  assign ram_we    = (accept & is_load & slot_in_range) | cmd_i.update;
  assign ram_waddr = cmd_i.update ? hit_idx_q : load_idx;
  assign ram_wdata = cmd_i.update ?
                     {hit_word_q[WORD_W-1:SIZE_BITS], new_cap} :
                     {target_id_i, target_score_i, SIZE_BITS'(target_capacity_i)};

  ffbp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_TARGETS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (rd_word)
  );

  assign sts_o.need_scan = (command_i == CMD_PLACE) & ~batch_failed_q;
  assign sts_o.hit       = hit;
  assign sts_o.miss      = miss;
  assign sts_o.out_free  = ~out_valid_q | ~out_stall_i;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blob_score_q   <= SCORE_ONE;
      batch_failed_q <= 1'b0;
      valid_q        <= '0;
      cnt_q          <= '0;
      rd_pend_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        blob_score_q <= cfg_data_i;
      end
      if (accept) begin
        cnt_q <= '0;
        if (is_load) begin
          if (slot_in_range) begin
            valid_q[load_idx] <= 1'b1;
          end
        end else if (batch_failed_q && batch_last_i) begin
          batch_failed_q <= 1'b0;
        end
      end else if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      // A zero-size request never fails the batch.
      if (miss && (size_q != '0)) begin
        batch_failed_q <= ~last_q;
      end
      rd_pend_q <= issue;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_idx_q <= cnt_q[IDX_W-1:0];
    end
    if (accept) begin
      size_q     <= SIZE_BITS'(item_size_i);
      last_q     <= batch_last_i;
      res_id_q   <= '0;
      res_size_q <= '0;
      res_status_q <= is_load ? ST_LOADED : ST_SKIP;
    end
    if (hit) begin
      hit_idx_q    <= rd_idx_q;
      hit_word_q   <= rd_word;
      res_status_q <= ST_PLACED;
      res_id_q     <= rd_id;
      res_size_q   <= IO_SIZE_W'(size_q);
    end else if (miss) begin
      res_status_q <= (size_q == '0) ? ST_PLACED : ST_NOSOL;
    end
    if (cmd_i.finish) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_size_q   <= res_size_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign placed_target_id_o = out_id_q;
  assign placed_size_o      = out_size_q;

endmodule

`default_nettype wire

FILE: rtl/core/first_fit_blob_placement_unit.sv
// First-fit placement of blobs over a table of MAX_TARGETS storage targets.
// A load request writes one target slot and is answered from the finish state.
// A place request walks the slots in order through the single read port of the
// slot table, one slot per cycle, and takes the first valid slot whose score is
// within blob_score and whose capacity holds the blob; its result is ready once
// the walk ends and, for a hit, the capacity is written back. Requests are
// handled one at a time; a finished result waits in the output register while
// the next request is taken. A failed placement marks the rest of its batch as
// skipped, up to and including the request with batch_last set.
// Depends on ffbp_pkg, ffbp_ctrl, ffbp_dp and ffbp_ram.
`default_nettype none

module first_fit_blob_placement_unit
  import ffbp_pkg::*;
#(
  parameter int unsigned MAX_TARGETS = 16,
  parameter int unsigned SIZE_BITS   = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [SCORE_W-1:0]   cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 command_i,
  input  wire logic [SLOT_W-1:0]    target_slot_i,
  input  wire logic [ID_W-1:0]      target_id_i,
  input  wire logic [IO_SIZE_W-1:0] target_capacity_i,
  input  wire logic [SCORE_W-1:0]   target_score_i,
  input  wire logic [IO_SIZE_W-1:0] item_size_i,
  input  wire logic                 batch_last_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                status_o,
  output logic [ID_W-1:0]           placed_target_id_o,
  output logic [IO_SIZE_W-1:0]      placed_size_o
);

  ffbp_cmd_t cmd;
  ffbp_sts_t sts;

  assign in_stall_o = ~cmd.take;

  ffbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffbp_dp #(
    .MAX_TARGETS (MAX_TARGETS),
    .SIZE_BITS   (SIZE_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .command_i          (command_i),
    .target_slot_i      (target_slot_i),
    .target_id_i        (target_id_i),
    .target_capacity_i  (target_capacity_i),
    .target_score_i     (target_score_i),
    .item_size_i        (item_size_i),
    .batch_last_i       (batch_last_i),
    .out_stall_i        (out_stall_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (out_valid_o),
    .status_o           (status_o),
    .placed_target_id_o (placed_target_id_o),
    .placed_size_o      (placed_size_o)
  );

endmodule

`default_nettype wire

FILE: sim/ffbp_tb_pkg.sv
// Request and result types plus the placement ledger used by the testbench.
// The ledger tracks the slot table and predicts each result in order.
// Depends on ffbp_pkg.

package ffbp_tb_pkg;

  import ffbp_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    cmd_e                 command;
    logic [SLOT_W-1:0]    slot;
    logic [ID_W-1:0]      ident;
    logic [IO_SIZE_W-1:0] capacity;
    logic [SCORE_W-1:0]   score;
    logic [IO_SIZE_W-1:0] item_size;
    logic                 batch_last;
  } placement_req_t;

  typedef struct packed {
    status_e              status;
    logic [ID_W-1:0]      ident;
    logic [IO_SIZE_W-1:0] size;
  } placement_res_t;

  class placement_ledger;
    logic [IO_SIZE_W-1:0] slot_room  [TABLE_DEPTH];
    logic [SCORE_W-1:0]   slot_rank  [TABLE_DEPTH];
    logic [ID_W-1:0]      slot_owner [TABLE_DEPTH];
    bit                   slot_live  [TABLE_DEPTH];
    bit                   batch_broken;
    logic [SCORE_W-1:0]   blob_limit;
    placement_res_t       pending_outcomes[$];
    int unsigned          mismatches;

    function new();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      batch_broken = 1'b0;
      blob_limit   = SCORE_ONE;
      mismatches   = 0;
    endfunction

    function void set_blob_limit(logic [SCORE_W-1:0] value);
      blob_limit = value;
    endfunction

    function int unsigned outstanding();
      return pending_outcomes.size();
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", what);
    endfunction

    // Apply one accepted request to the table and queue the result it owes.
    function void note_request(placement_req_t req);
      placement_res_t res;
      int             pick;
      res  = '{status: ST_LOADED, ident: '0, size: '0};
      pick = -1;
      if (req.command == CMD_LOAD) begin
        slot_owner[req.slot] = req.ident;
        slot_room[req.slot]  = req.capacity;
        slot_rank[req.slot]  = req.score;
        slot_live[req.slot]  = 1'b1;
      end else if (batch_broken) begin
        res.status = ST_SKIP;
        if (req.batch_last) batch_broken = 1'b0;
      end else begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (pick < 0 && slot_live[i] && slot_rank[i] <= blob_limit &&
              slot_room[i] >= req.item_size) pick = i;
        end
        if (pick >= 0) begin
          slot_room[pick] = slot_room[pick] - req.item_size;
          res.status = ST_PLACED;
          res.ident  = slot_owner[pick];
          res.size   = req.item_size;
        end else if (req.item_size == '0) begin
          // A zero-size blob never fails, even with no usable slot.
          res.status = ST_PLACED;
        end else begin
          res.status   = ST_NOSOL;
          batch_broken = !req.batch_last;
        end
      end
      pending_outcomes.push_back(res);
    endfunction

    function void check_outcome(logic [1:0] status, logic [ID_W-1:0] ident,
                                logic [IO_SIZE_W-1:0] size);
      placement_res_t want;
      if (pending_outcomes.size() == 0) begin
        report($sformatf("Unexpected result: status %0d id %h size %h",
                         status, ident, size));
        return;
      end
      want = pending_outcomes.pop_front();
      if (status !== want.status || ident !== want.ident || size !== want.size) begin
        report($sformatf({"Result mismatch: expected status %0d id %h size %h, ",
                          "got status %0d id %h size %h"},
                         want.status, want.ident, want.size, status, ident, size));
      end
    endfunction
  endclass

endpackage

FILE: sim/testbench.sv
// Self-checking testbench for first_fit_blob_placement_unit.
// Drives load and place requests with random gaps and stalls, predicts every result
// with the placement ledger from ffbp_tb_pkg, and checks the results in order.

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import ffbp_pkg::*;
  import ffbp_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned PHASE_ITEMS   = 194;

  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 cfg_we_i          = 1'b0;
  logic [SCORE_W-1:0]   cfg_data_i        = '0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_stall_o;
  logic                 command_i         = 1'b0;
  logic [SLOT_W-1:0]    target_slot_i     = '0;
  logic [ID_W-1:0]      target_id_i       = '0;
  logic [IO_SIZE_W-1:0] target_capacity_i = '0;
  logic [SCORE_W-1:0]   target_score_i    = '0;
  logic [IO_SIZE_W-1:0] item_size_i       = '0;
  logic                 batch_last_i      = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i       = 1'b0;
  logic [1:0]           status_o;
  logic [ID_W-1:0]      placed_target_id_o;
  logic [IO_SIZE_W-1:0] placed_size_o;

  placement_ledger ledger;
  bit              tx_calm     = 1'b0;
  bit              rx_calm     = 1'b0;
  int unsigned     cycle_count = 0;

  first_fit_blob_placement_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .target_slot_i     (target_slot_i),
    .target_id_i       (target_id_i),
    .target_capacity_i (target_capacity_i),
    .target_score_i    (target_score_i),
    .item_size_i       (item_size_i),
    .batch_last_i      (batch_last_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .placed_target_id_o(placed_target_id_o),
    .placed_size_o     (placed_size_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      ledger.check_outcome(status_o, placed_target_id_o, placed_size_o);
    end
  end

  // Mostly short gaps, now and then a long one, none at all while calm.
  function automatic int unsigned idle_length(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    else if (roll < 92) return $urandom_range(1, 3);
    else return $urandom_range(6, 40);
  endfunction

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 249) == 0) rx_calm = !rx_calm;
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = idle_length(rx_calm);
      end
    end
  end

  function automatic logic [IO_SIZE_W-1:0] random_wide();
    return {16'($urandom()), $urandom()};
  endfunction

  function automatic placement_req_t random_fields();
    placement_req_t req;
    req.command    = cmd_e'($urandom_range(0, 1));
    req.slot       = SLOT_W'($urandom());
    req.ident      = $urandom();
    req.capacity   = random_wide();
    req.score      = SCORE_W'($urandom());
    req.item_size  = random_wide();
    req.batch_last = 1'($urandom());
    return req;
  endfunction

  function automatic placement_req_t make_load(logic [SLOT_W-1:0] slot,
                                               logic [ID_W-1:0] ident,
                                               logic [IO_SIZE_W-1:0] capacity,
                                               logic [SCORE_W-1:0] score);
    placement_req_t req;
    req          = random_fields();
    req.command  = CMD_LOAD;
    req.slot     = slot;
    req.ident    = ident;
    req.capacity = capacity;
    req.score    = score;
    return req;
  endfunction

  function automatic placement_req_t make_place(logic [IO_SIZE_W-1:0] size, logic last);
    placement_req_t req;
    req            = random_fields();
    req.command    = CMD_PLACE;
    req.item_size  = size;
    req.batch_last = last;
    return req;
  endfunction

  function automatic placement_req_t random_load();
    logic [IO_SIZE_W-1:0] capacity;
    logic [SCORE_W-1:0]   score;
    int unsigned          roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) capacity = IO_SIZE_W'($urandom_range(0, 4000));
    else if (roll < 85) capacity = '0;
    else if (roll < 95) capacity = random_wide();
    else capacity = '1;
    roll = $urandom_range(0, 99);
    if (roll < 50) score = SCORE_W'($urandom_range(0, 65536));
    else if (roll < 65) score = '0;
    else if (roll < 75) score = SCORE_ONE;
    else if (roll < 90) score = SCORE_W'($urandom());
    else score = '1;
    return make_load(SLOT_W'($urandom()), $urandom(), capacity, score);
  endfunction

  function automatic placement_req_t random_place(logic last);
    logic [IO_SIZE_W-1:0] size;
    int unsigned          roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) size = '0;
    else if (roll < 80) size = IO_SIZE_W'($urandom_range(1, 1500));
    else if (roll < 90) size = IO_SIZE_W'($urandom_range(1, 8000));
    else if (roll < 97) size = random_wide();
    else size = '1;
    return make_place(size, last);
  endfunction

  task automatic put_request(input placement_req_t req);
    int unsigned gap;
    in_valid_i        <= 1'b1;
    command_i         <= req.command;
    target_slot_i     <= req.slot;
    target_id_i       <= req.ident;
    target_capacity_i <= req.capacity;
    target_score_i    <= req.score;
    item_size_i       <= req.item_size;
    batch_last_i      <= req.batch_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.note_request(req);
    gap = idle_length(tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // The sender holds off until every owed result has come back.
  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_blob_limit(input logic [SCORE_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    ledger.set_blob_limit(value);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    // Empty table: a zero-size blob is still placed, a real one fails the batch.
    put_request(make_place(48'd0, 1'b1));
    put_request(make_place(48'd5, 1'b0));
    put_request(make_load(4'd3, 32'h1234_5678, 48'd10, 17'd0));
    put_request(make_place(48'd1, 1'b0));
    put_request(make_place(48'd1, 1'b1));
    put_request(make_load(4'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, SCORE_ONE));
    put_request(make_load(4'd15, 32'd0, 48'd0, 17'd0));
    put_request(make_load(4'd1, 32'hA5A5_5A5A, 48'd100, 17'd65537));
    put_request(make_place(48'hFFFF_FFFF_FFFF, 1'b1));
    put_request(make_place(48'd10, 1'b0));
    put_request(make_place(48'd0, 1'b0));
    put_request(make_place(48'd1, 1'b1));
    put_request(make_place(48'd0, 1'b1));
    put_request(make_place(48'd1, 1'b0));
    // Skipped even though a zero-size blob could never fail on its own.
    put_request(make_place(48'd0, 1'b1));
    put_request(make_load(4'd7, 32'h0F0F_0F0F, 48'h8000_0000_0001, 17'h1FFFF));
    put_request(make_place(48'd2, 1'b1));
  endtask

  // Load rounds and placement batches with random content, plus some noise:
  // loads inside a batch, batches closed early or left open, and raw requests.
  task automatic run_random_phase(input int unsigned count);
    int unsigned sent;
    int unsigned roll;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 28) begin
        len = $urandom_range(1, 5);
        repeat (len) put_request(random_load());
        sent += len;
      end else if (roll < 93) begin
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 9) == 0) begin
            put_request(random_load());
            sent++;
          end
          put_request(random_place((j == len - 1) ? ($urandom_range(0, 11) != 0)
                                                  : ($urandom_range(0, 11) == 0)));
          sent++;
        end
      end else begin
        put_request(random_fields());
        sent++;
      end
    end
  endtask

  initial begin
    logic [SCORE_W-1:0] limits [8];
    ledger = new();
    limits = '{SCORE_ONE, 17'd0, 17'h1FFFF, 17'd32768, SCORE_W'($urandom()), 17'd1,
               17'd65535, SCORE_W'($urandom_range(0, 65536))};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    settle_pipeline();
    foreach (limits[p]) begin
      program_blob_limit(limits[p]);
      tx_calm = ($urandom_range(0, 3) == 0);
      run_random_phase(PHASE_ITEMS);
      settle_pipeline();
    end
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
